### src/assert_macros.svh
// Assertion macros used by the checker file pbba_chk.sv.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define PBBA_ASSERT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define PBBA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/pbba_pkg.sv
// Shared types, constants and saturation helpers for the particle box accumulator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pbba_pkg;

    localparam int DATA_W        = 32;
    localparam int SIZE_W        = 31;
    localparam int NUM_AXES      = 3;
    localparam int FRAC_BITS_DEF = 16;
    localparam int CFG_IDX_W     = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_WORLD_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_X     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_Y     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_Z     = 2'd3;

    typedef struct packed {
        logic signed [DATA_W-1:0] pos_x;
        logic signed [DATA_W-1:0] pos_y;
        logic signed [DATA_W-1:0] pos_z;
        logic        [SIZE_W-1:0] part_size;
        logic signed [DATA_W-1:0] dist_x;
        logic signed [DATA_W-1:0] dist_y;
        logic signed [DATA_W-1:0] dist_z;
        logic                     is_distorted;
        logic                     is_active;
        logic                     last_item;
    } pbba_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] min_x;
        logic signed [DATA_W-1:0] min_y;
        logic signed [DATA_W-1:0] min_z;
        logic signed [DATA_W-1:0] max_x;
        logic signed [DATA_W-1:0] max_y;
        logic signed [DATA_W-1:0] max_z;
        logic                     any_active;
    } pbba_out_t;

    // Box update controls, computed once and shared by the axis lanes.
    typedef struct packed {
        logic first;   // first active particle: box takes bare position
        logic upd;     // later active particle: extend box
        logic clear;   // last item: box returns to zero after snapshot
    } pbba_ctl_t;

    typedef struct packed {
        logic active;
        logic last;
    } pbba_flags_t;

    function automatic logic signed [63:0] sx64(input logic signed [DATA_W-1:0] v);
        sx64 = {{(64-DATA_W){v[DATA_W-1]}}, v};
    endfunction

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = sx64({1'b0, {(DATA_W-1){1'b1}}});
        lo = sx64({1'b1, {(DATA_W-1){1'b0}}});
        if (v > hi)
            sat32 = {1'b0, {(DATA_W-1){1'b1}}};
        else if (v < lo)
            sat32 = {1'b1, {(DATA_W-1){1'b0}}};
        else
            sat32 = v[DATA_W-1:0];
    endfunction

endpackage

`default_nettype wire

### src/particle_bounding_box_accumulator.sv
// Top level of the particle bounding-box accumulator.
// Depends on pbba_pkg and pbba_axis.
//
// Streams one particle per cycle and emits one axis-aligned box on every item
// marked last. Sustained rate is one item per clock while in_stall is low; the
// last item passes the input register, product register, candidate register,
// box snapshot and output register before out_valid rises. The rate is set by
// the running min/max update, which closes on itself every cycle. A holding
// register ahead of the output register lets input keep flowing while one
// result waits; in_stall rises only when both are full and out_stall is high.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must
// write it only while idle, and the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module particle_bounding_box_accumulator #(
    parameter int FRAC_BITS = pbba_pkg::FRAC_BITS_DEF
) (
    input  wire                                     clk,
    input  wire                                     rst_n,
    input  wire                                     in_valid,
    output logic                                    in_stall,
    input  wire pbba_pkg::pbba_in_t                 in_data,
    output logic                                    out_valid,
    input  wire                                     out_stall,
    output pbba_pkg::pbba_out_t                     out_data,
    input  wire                                     cfg_we,
    input  wire logic [pbba_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [pbba_pkg::DATA_W-1:0]        cfg_data
);

    localparam int NA = pbba_pkg::NUM_AXES;

    logic                                   world_mode_reg;
    logic signed [pbba_pkg::DATA_W-1:0]     node_reg [NA];

    logic                                   s1_v_reg;
    pbba_pkg::pbba_in_t                     s1_reg;
    logic                                   s2_v_reg;
    pbba_pkg::pbba_flags_t                  s2_flags_reg;
    logic                                   s3_v_reg;
    pbba_pkg::pbba_flags_t                  s3_flags_reg;
    logic                                   seen_reg;
    logic                                   seen_next;

    logic                                   s4_v_reg;
    logic signed [pbba_pkg::DATA_W-1:0]     s4_low_reg  [NA];
    logic signed [pbba_pkg::DATA_W-1:0]     s4_high_reg [NA];
    logic                                   s4_any_reg;

    logic                                   out_valid_reg;
    pbba_pkg::pbba_out_t                    out_reg;
    pbba_pkg::pbba_out_t                    out_next;

    logic                                   en;
    logic                                   out_free;
    pbba_pkg::pbba_ctl_t                    ctl;

    logic signed [pbba_pkg::DATA_W-1:0]     pos_a  [NA];
    logic signed [pbba_pkg::DATA_W-1:0]     dist_a [NA];
    logic signed [pbba_pkg::DATA_W-1:0]     low_next  [NA];
    logic signed [pbba_pkg::DATA_W-1:0]     high_next [NA];
    logic signed [pbba_pkg::DATA_W-1:0]     lo_out [NA];
    logic signed [pbba_pkg::DATA_W-1:0]     hi_out [NA];

    // pipeline moves unless the holding register is full and cannot drain
    assign out_free  = !out_valid_reg || !out_stall;
    assign en        = !(s4_v_reg && !out_free);
    assign in_stall  = !en;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            world_mode_reg <= 1'b1;
            for (int i = 0; i < NA; i++)
                node_reg[i] <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pbba_pkg::CFG_WORLD_MODE: world_mode_reg <= cfg_data[0];
                pbba_pkg::CFG_NODE_X:     node_reg[0]    <= cfg_data;
                pbba_pkg::CFG_NODE_Y:     node_reg[1]    <= cfg_data;
                pbba_pkg::CFG_NODE_Z:     node_reg[2]    <= cfg_data;
                default:                  world_mode_reg <= world_mode_reg;
            endcase
        end
    end

    assign pos_a[0]  = s1_reg.pos_x;
    assign pos_a[1]  = s1_reg.pos_y;
    assign pos_a[2]  = s1_reg.pos_z;
    assign dist_a[0] = s1_reg.dist_x;
    assign dist_a[1] = s1_reg.dist_y;
    assign dist_a[2] = s1_reg.dist_z;

    assign ctl.first = s3_v_reg && s3_flags_reg.active && !seen_reg;
    assign ctl.upd   = s3_v_reg && s3_flags_reg.active && seen_reg;
    assign ctl.clear = s3_v_reg && s3_flags_reg.last;
    assign seen_next = seen_reg || (s3_v_reg && s3_flags_reg.active);

    for (genvar g = 0; g < NA; g++)
    begin : g_axis
        pbba_axis #(
            .FRAC_BITS (FRAC_BITS)
        ) u_axis (
            .clk           (clk),
            .rst_n         (rst_n),
            .en            (en),
            .ctl           (ctl),
            .pos           (pos_a[g]),
            .dvec          (dist_a[g]),
            .size          (s1_reg.part_size),
            .distorted     (s1_reg.is_distorted),
            .box_low_next  (low_next[g]),
            .box_high_next (high_next[g])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg              <= in_data;
            s2_flags_reg.active <= s1_reg.is_active;
            s2_flags_reg.last   <= s1_reg.last_item;
            s3_flags_reg        <= s2_flags_reg;
            s4_low_reg          <= low_next;
            s4_high_reg         <= high_next;
            s4_any_reg          <= seen_next;
        end
        if (out_free)
            out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            s3_v_reg      <= 1'b0;
            s4_v_reg      <= 1'b0;
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                s1_v_reg <= in_valid;
                s2_v_reg <= s1_v_reg;
                s3_v_reg <= s2_v_reg;
                s4_v_reg <= s3_v_reg && s3_flags_reg.last;
                seen_reg <= ctl.clear ? 1'b0 : seen_next;
            end
            if (out_free)
                out_valid_reg <= s4_v_reg;
        end
    end

    // node-space shift on the way out, in world mode only
    always_comb
    begin
        for (int i = 0; i < NA; i++)
        begin
            if (world_mode_reg)
            begin
                lo_out[i] = pbba_pkg::sat32(pbba_pkg::sx64(s4_low_reg[i])
                                            - pbba_pkg::sx64(node_reg[i]));
                hi_out[i] = pbba_pkg::sat32(pbba_pkg::sx64(s4_high_reg[i])
                                            - pbba_pkg::sx64(node_reg[i]));
            end
            else
            begin
                lo_out[i] = s4_low_reg[i];
                hi_out[i] = s4_high_reg[i];
            end
        end
        out_next.min_x      = lo_out[0];
        out_next.min_y      = lo_out[1];
        out_next.min_z      = lo_out[2];
        out_next.max_x      = hi_out[0];
        out_next.max_y      = hi_out[1];
        out_next.max_z      = hi_out[2];
        out_next.any_active = s4_any_reg;
    end

endmodule

`default_nettype wire

### src/pbba_axis.sv
// One axis lane: distortion product, extent candidates and running box bounds.
// Depends on pbba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pbba_axis #(
    parameter int FRAC_BITS = pbba_pkg::FRAC_BITS_DEF
) (
    input  wire                                         clk,
    input  wire                                         rst_n,
    input  wire                                         en,
    input  wire pbba_pkg::pbba_ctl_t                    ctl,
    input  wire logic signed [pbba_pkg::DATA_W-1:0]     pos,
    input  wire logic signed [pbba_pkg::DATA_W-1:0]     dvec,
    input  wire logic        [pbba_pkg::SIZE_W-1:0]     size,
    input  wire                                         distorted,
    output logic signed      [pbba_pkg::DATA_W-1:0]     box_low_next,
    output logic signed      [pbba_pkg::DATA_W-1:0]     box_high_next
);

    // product stage
    logic signed [63:0]                     prod_reg;
    logic signed [pbba_pkg::DATA_W-1:0]     pos2_reg;
    logic        [pbba_pkg::SIZE_W-1:0]     size2_reg;
    logic                                   dis2_reg;

    // candidate stage
    logic signed [pbba_pkg::DATA_W-1:0]     pos3_reg;
    logic signed [pbba_pkg::DATA_W-1:0]     cand_a_reg;
    logic signed [pbba_pkg::DATA_W-1:0]     cand_b_reg;

    logic signed [pbba_pkg::DATA_W-1:0]     box_low_reg;
    logic signed [pbba_pkg::DATA_W-1:0]     box_high_reg;

    logic signed [pbba_pkg::DATA_W-1:0]     size_s;
    logic signed [63:0]                     prod_next;
    logic signed [63:0]                     prod_shift;
    logic signed [pbba_pkg::DATA_W-1:0]     term;
    logic signed [pbba_pkg::DATA_W-1:0]     cand_a_next;
    logic signed [pbba_pkg::DATA_W-1:0]     cand_b_next;
    logic signed [pbba_pkg::DATA_W-1:0]     lo_ab;
    logic signed [pbba_pkg::DATA_W-1:0]     hi_ab;

    assign size_s    = {1'b0, size};
    assign prod_next = dvec * size_s;

    // arithmetic shift floors toward minus infinity
    assign prod_shift  = prod_reg >>> FRAC_BITS;
    assign term        = dis2_reg ? pbba_pkg::sat32(prod_shift)
                                  : {1'b0, size2_reg};
    assign cand_a_next = pbba_pkg::sat32(pbba_pkg::sx64(pos2_reg) - pbba_pkg::sx64(term));
    assign cand_b_next = pbba_pkg::sat32(pbba_pkg::sx64(pos2_reg) + pbba_pkg::sx64(term));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg   <= prod_next;
            pos2_reg   <= pos;
            size2_reg  <= size;
            dis2_reg   <= distorted;
            pos3_reg   <= pos2_reg;
            cand_a_reg <= cand_a_next;
            cand_b_reg <= cand_b_next;
        end
    end

    always_comb
    begin
        lo_ab = (cand_a_reg < cand_b_reg) ? cand_a_reg : cand_b_reg;
        hi_ab = (cand_a_reg > cand_b_reg) ? cand_a_reg : cand_b_reg;
        box_low_next  = box_low_reg;
        box_high_next = box_high_reg;
        if (ctl.first)
        begin
            box_low_next  = pos3_reg;
            box_high_next = pos3_reg;
        end
        else if (ctl.upd)
        begin
            if (lo_ab < box_low_reg)
                box_low_next = lo_ab;
            if (hi_ab > box_high_reg)
                box_high_next = hi_ab;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_low_reg  <= '0;
            box_high_reg <= '0;
        end
        else if (en)
        begin
            box_low_reg  <= ctl.clear ? '0 : box_low_next;
            box_high_reg <= ctl.clear ? '0 : box_high_next;
        end
    end

endmodule

`default_nettype wire

### src/pbba_chk.sv
// Port-level checker for the particle bounding-box accumulator, bound to the top.
// Depends on pbba_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pbba_chk (
    input  wire                                     clk,
    input  wire                                     rst_n,
    input  wire                                     in_stall,
    input  wire                                     out_valid,
    input  wire                                     out_stall,
    input  wire pbba_pkg::pbba_out_t                out_data
);

    // a stalled result holds until its transfer
    `PBBA_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(out_data), "stalled result changed")

    // input backs up only behind a stalled, full output
    `PBBA_ASSERT(a_stall_cause, clk, rst_n, in_stall,
        out_valid && out_stall, "input stalled without output backpressure")

    // the box never comes out inverted
    `PBBA_ASSERT(a_box_order, clk, rst_n, out_valid,
        out_data.min_x <= out_data.max_x && out_data.min_y <= out_data.max_y
        && out_data.min_z <= out_data.max_z, "box min above max")

    // an empty group gives a degenerate box
    `PBBA_ASSERT(a_empty_box, clk, rst_n, out_valid && !out_data.any_active,
        out_data.min_x == out_data.max_x && out_data.min_y == out_data.max_y
        && out_data.min_z == out_data.max_z, "empty group with nonzero extent")

endmodule

bind particle_bounding_box_accumulator pbba_chk u_pbba_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

`default_nettype wire
